// ===== rtl/itoa_pkg.sv =====
// Shared types, constants and helpers for the integer-to-radix-ASCII block.
// No dependencies; imported by itoa_div, integer_to_radix_ascii_core and itoa_chk.
`default_nettype none

package itoa_pkg;

  localparam int RADIX_W   = 6;
  localparam int CHAR_W    = 7;
  localparam int LEN_W     = 6;
  localparam int STEP_BITS = 4;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2d;
  localparam logic [CHAR_W-1:0] DIGIT_ALPHA  = 7'd10;

  typedef struct packed {
    logic done;
    logic quot_zero;
  } div_stat_t;

  function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      return RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (dx < DIGIT_ALPHA) begin
      return CHAR_ZERO + dx;
    end
    return CHAR_LOWER_A + dx - DIGIT_ALPHA;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/itoa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module itoa_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/itoa_div.sv =====
// Iterative divider: value by a 6-bit radix, STEP_BITS quotient bits a cycle.
// Depends on itoa_pkg.
`default_nettype none

module itoa_div #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [VALUE_WIDTH-1:0]        dividend,
  input  logic [itoa_pkg::RADIX_W-1:0]  divisor,
  output logic [VALUE_WIDTH-1:0]        quotient,
  output logic [itoa_pkg::RADIX_W-1:0]  remainder,
  output itoa_pkg::div_stat_t           stat
);
  import itoa_pkg::*;

  localparam int PW    = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int NSTEP = PW / STEP_BITS;
  localparam int CW    = $clog2(NSTEP);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [PW-1:0]        work_r, work_nxt;
  logic [RADIX_W-1:0]   rem_r, rem_nxt;
  logic [RADIX_W-1:0]   div_r, div_nxt;

  logic [RADIX_W:0]     trial;
  logic [RADIX_W-1:0]   rem_c;
  logic [STEP_BITS-1:0] q_c;

  always_comb begin
    rem_c = rem_r;
    q_c   = '0;
    trial = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {rem_c, work_r[PW-1-i]};
      if (trial >= {1'b0, div_r}) begin
        q_c[STEP_BITS-1-i] = 1'b1;
        trial = trial - {1'b0, div_r};
      end
      rem_c = trial[RADIX_W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      work_nxt = PW'(dividend);
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      work_nxt = {work_r[PW-STEP_BITS-1:0], q_c};
      rem_nxt  = rem_c;
      cnt_nxt  = cnt_r + CW'(1);
      if (cnt_r == CW'(NSTEP - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
  end

  assign quotient       = work_r[VALUE_WIDTH-1:0];
  assign remainder      = rem_r;
  assign stat.done      = done_r;
  assign stat.quot_zero = (work_r[VALUE_WIDTH-1:0] == '0);

endmodule

`default_nettype wire

// ===== rtl/integer_to_radix_ascii_core.sv =====
// Integer to ASCII text in a configurable radix, top level.
// Depends on itoa_pkg, itoa_div and itoa_ram.
//
// Usage:
//   Input channel in_valid/in_ready/in_number takes one value per item.
//   Output channel out_valid/out_ready carries one character per item,
//   most significant first, with out_is_last on the final character and
//   out_text_length (characters incl. sign) on every one.
//   cfg_we/cfg_data write the radix (reset 10; below 2 acts as 2, above
//   36 as 36). In radix 10 a set sign bit gives '-' and the magnitude.
// Timing:
//   Each digit costs one pass of the shared 4-bit-per-cycle divider.
//   Each character is then read back from the digit RAM in the FETCH
//   state and loaded in the SHOW state once the output register is free.
//   in_ready is high only while idle; it rises once the last character
//   is loaded into the output register, even if that character waits.
// Reset: synchronous, clears the sequencer and output valid, radix = 10.
// Stall: a held out_ready freezes the output register; the sequencer waits in SIGN or SHOW, but division goes on.
`default_nettype none

module integer_to_radix_ascii_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [31:0]           in_number,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [itoa_pkg::CHAR_W-1:0]  out_text_char,
  output logic                         out_is_last,
  output logic [itoa_pkg::LEN_W-1:0]   out_text_length,
  input  logic                         cfg_we,
  input  logic [itoa_pkg::RADIX_W-1:0] cfg_data
);
  import itoa_pkg::*;

  localparam int AW    = $clog2(VALUE_WIDTH);
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int SUM_W = (CNT_W + 1 > LEN_W) ? CNT_W + 1 : LEN_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_SIGN  = 3'd2;
  localparam logic [2:0] ST_FETCH = 3'd3;
  localparam logic [2:0] ST_SHOW  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [RADIX_W-1:0] radix_r, radix_nxt;
  logic [RADIX_W-1:0] reff_r, reff_nxt;
  logic               neg_r, neg_nxt;
  logic [CNT_W-1:0]   ndig_r, ndig_nxt;
  logic [AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;
  logic [LEN_W-1:0]   out_len_r, out_len_nxt;

  logic [VALUE_WIDTH-1:0] num_w, in_mag;
  logic [RADIX_W-1:0]     in_reff;
  logic                   in_neg, accept, slot;
  logic [SUM_W-1:0]       len_sum;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend, div_quot;
  logic [RADIX_W-1:0]     div_divisor, div_rem;
  div_stat_t              div_stat;

  logic                   ram_we;
  logic [RADIX_W-1:0]     ram_rdata;

  assign num_w   = VALUE_WIDTH'(in_number);
  assign in_reff = sat_radix(radix_r);
  assign in_neg  = (in_reff == RADIX_DEC) && num_w[VALUE_WIDTH-1];
  assign in_mag  = in_neg ? (~num_w + VALUE_WIDTH'(1)) : num_w;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign slot     = !out_valid_r || out_ready;
  assign len_sum  = SUM_W'(ndig_r) + SUM_W'(1) + SUM_W'(neg_r);

  assign div_start    = accept ||
                        ((state_r == ST_DIV) && div_stat.done && !div_stat.quot_zero);
  assign div_dividend = accept ? in_mag : div_quot;
  assign div_divisor  = accept ? in_reff : reff_r;
  assign ram_we       = (state_r == ST_DIV) && div_stat.done;

  itoa_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .remainder(div_rem),
    .stat     (div_stat)
  );

  itoa_ram #(
    .WIDTH(RADIX_W),
    .DEPTH(VALUE_WIDTH)
  ) u_digits (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ndig_r[AW-1:0]),
    .wdata(div_rem),
    .raddr(rd_ptr_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    radix_nxt     = cfg_we ? cfg_data : radix_r;
    reff_nxt      = reff_r;
    neg_nxt       = neg_r;
    ndig_nxt      = ndig_r;
    rd_ptr_nxt    = rd_ptr_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_len_nxt   = out_len_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          neg_nxt   = in_neg;
          reff_nxt  = in_reff;
          ndig_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          ndig_nxt = ndig_r + CNT_W'(1);
          if (div_stat.quot_zero) begin
            len_nxt    = len_sum[LEN_W-1:0];
            rd_ptr_nxt = ndig_r[AW-1:0];
            state_nxt  = ST_SIGN;
          end
        end
      end
      ST_SIGN: begin
        if (!neg_r) begin
          state_nxt = ST_FETCH;
        end else if (slot) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = (len_r == LEN_W'(1));
          out_len_nxt   = len_r;
          state_nxt     = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        if (slot) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(ram_rdata);
          out_last_nxt  = (rd_ptr_r == '0);
          out_len_nxt   = len_r;
          if (rd_ptr_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_ptr_nxt = rd_ptr_r - AW'(1);
            state_nxt  = ST_FETCH;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radix_r     <= RADIX_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      radix_r     <= radix_nxt;
      out_valid_r <= out_valid_nxt;
    end
    reff_r     <= reff_nxt;
    neg_r      <= neg_nxt;
    ndig_r     <= ndig_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    len_r      <= len_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_len_r  <= out_len_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_text_char   = out_char_r;
  assign out_is_last     = out_last_r;
  assign out_text_length = out_len_r;

endmodule

`default_nettype wire

// ===== rtl/itoa_chk.sv =====
// Port-level checker for integer_to_radix_ascii_core, bound to the top level.
// Depends on itoa_pkg.
`default_nettype none

module itoa_chk (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         in_valid,
  input wire                         in_ready,
  input wire                         out_valid,
  input wire                         out_ready,
  input wire [itoa_pkg::CHAR_W-1:0]  out_text_char,
  input wire                         out_is_last,
  input wire [itoa_pkg::LEN_W-1:0]   out_text_length
);
  import itoa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_text_char) &&
      $stable(out_is_last) && $stable(out_text_length))
    else $error("stalled item changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while converting");

  a_len_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_is_last |=> $stable(out_text_length))
    else $error("length changed within a number");

  a_busy_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |-> !in_ready)
    else $error("idle before last character");

endmodule

bind integer_to_radix_ascii_core itoa_chk u_itoa_chk (.*);

`default_nettype wire
